FILE: rtl/core/periodic_task_release_table_macros.svh
// Assertion helpers used by the RTL datapath.
`ifndef PERIODIC_TASK_RELEASE_TABLE_MACROS_SVH
`define PERIODIC_TASK_RELEASE_TABLE_MACROS_SVH

// Check a property on every rising clk_i edge outside reset.
`define PTRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define PTRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ptrt_pkg.sv
package ptrt_pkg;

  localparam int DefSlots   = 8;
  localparam int MaxResults = 8;
  localparam int CntW       = $clog2(MaxResults + 1);
  localparam int ModeW      = 3;
  localparam int SlotFieldW = 3;
  localparam int TimeW      = 16;
  localparam int StatusW    = 3;

  typedef enum logic [ModeW-1:0] {
    MODE_TICK    = 3'd0,
    MODE_CREATE  = 3'd1,
    MODE_SUSPEND = 3'd2,
    MODE_RESUME  = 3'd3,
    MODE_DELETE  = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_OCCUPIED  = 3'd1,
    ST_SUSPENDED = 3'd2,
    ST_RUNNING   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    logic cmd_go;
    logic tick_go;
    logic walk;
    logic flush;
  } ctrl_t;

  typedef struct packed {
    logic walk_last;
  } stat_t;

endpackage

FILE: rtl/core/ptrt_ram.sv
module ptrt_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ptrt_ctrl.sv
module ptrt_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ptrt_pkg::ModeW-1:0]       mode_i,
  input  ptrt_pkg::stat_t                  stat_i,
  output ptrt_pkg::ctrl_t                  ctrl_o,
  output logic                             busy_o
);
  import ptrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   accept;

  assign accept = start_i && !busy_q && (state_q == S_IDLE);

  always_comb begin
    ctrl_o.cmd_go  = accept && (mode_e'(mode_i) != MODE_TICK);
    ctrl_o.tick_go = accept && (mode_e'(mode_i) == MODE_TICK);
    ctrl_o.walk    = (state_q == S_WALK);
    ctrl_o.flush   = (state_q == S_FLUSH);
  end

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    case (state_q)
      S_IDLE: begin
        if (ctrl_o.tick_go) begin
          state_d = S_WALK;
          busy_d  = 1'b1;
        end
      end
      S_WALK: begin
        if (stat_i.walk_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

FILE: rtl/core/ptrt_datapath.sv
`include "periodic_task_release_table_macros.svh"

module ptrt_datapath #(
  parameter int Slots = ptrt_pkg::DefSlots
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ptrt_pkg::ctrl_t                    ctrl_i,
  output ptrt_pkg::stat_t                    stat_o,
  input  logic [ptrt_pkg::ModeW-1:0]         mode_i,
  input  logic [ptrt_pkg::SlotFieldW-1:0]    slot_i,
  input  logic [ptrt_pkg::TimeW-1:0]         first_delay_i,
  input  logic [ptrt_pkg::TimeW-1:0]         period_i,
  input  logic                               runnable_i,
  output logic                               done_o,
  output logic [ptrt_pkg::StatusW-1:0]       status_o,
  output logic                               fired_o,
  output logic [ptrt_pkg::SlotFieldW-1:0]    fired_slot_o,
  output logic                               last_o
);
  import ptrt_pkg::*;

  localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int ExtW  = 7;

  logic [Slots-1:0]        occ_q, susp_q, vld_q;
  logic [SlotW-1:0]        idx_q;
  logic                    held_q;
  logic [SlotFieldW-1:0]   held_slot_q;
  logic [CntW-1:0]         cnt_q;
  logic                    strobe_q, fired_q, last_q;
  logic [StatusW-1:0]      status_q;
  logic [SlotFieldW-1:0]   fslot_q;

  logic [ExtW-1:0]         slot_ext, idx_ext;
  logic                    ok_slot;
  logic [SlotW-1:0]        sidx;
  logic                    we;
  logic [SlotW-1:0]        waddr, raddr;
  logic [2*TimeW-1:0]      wdata, rdata;
  logic [TimeW-1:0]        cd_eff, per_eff;
  logic                    fire, report;
  status_e                 cmd_status;

  assign slot_ext = {{(ExtW-SlotFieldW){1'b0}}, slot_i};
  assign idx_ext  = {{(ExtW-SlotW){1'b0}}, idx_q};
  assign ok_slot  = slot_ext < ExtW'(Slots);
  assign sidx     = slot_ext[SlotW-1:0];

  assign stat_o.walk_last = (idx_q == SlotW'(Slots - 1));

  assign cd_eff  = vld_q[idx_q] ? rdata[TimeW-1:0] : '0;
  assign per_eff = vld_q[idx_q] ? rdata[2*TimeW-1:TimeW] : '0;

  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = {per_eff, cd_eff};
    fire  = 1'b0;
    if (ctrl_i.cmd_go && (mode_e'(mode_i) == MODE_CREATE) && ok_slot && !occ_q[sidx]) begin
      we    = 1'b1;
      waddr = sidx;
      wdata = {period_i, first_delay_i};
    end else if (ctrl_i.walk && !susp_q[idx_q]) begin
      if (cd_eff == '0) begin
        if (occ_q[idx_q]) begin
          we    = 1'b1;
          wdata = {per_eff, per_eff - 1'b1};
          fire  = 1'b1;
        end
      end else begin
        we    = 1'b1;
        wdata = {per_eff, cd_eff - 1'b1};
      end
    end
  end

  assign report = fire && (cnt_q < CntW'(MaxResults));
  assign raddr  = (ctrl_i.walk && !stat_o.walk_last) ? idx_q + 1'b1 : '0;

  always_comb begin
    cmd_status = ST_OK;
    case (mode_e'(mode_i))
      MODE_CREATE:  if (!(ok_slot && !occ_q[sidx]))  cmd_status = ST_OCCUPIED;
      MODE_SUSPEND: if (!(ok_slot && !susp_q[sidx])) cmd_status = ST_SUSPENDED;
      MODE_RESUME:  if (!(ok_slot && susp_q[sidx]))  cmd_status = ST_RUNNING;
      MODE_DELETE:  if (!(ok_slot && occ_q[sidx]))   cmd_status = ST_EMPTY;
      default:      cmd_status = ST_OK;
    endcase
  end

  ptrt_ram #(
    .Width (2 * TimeW),
    .Depth (Slots)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      susp_q   <= '0;
      vld_q    <= '0;
      idx_q    <= '0;
      held_q   <= 1'b0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (ctrl_i.cmd_go || ctrl_i.flush) begin
        strobe_q <= 1'b1;
      end else if (ctrl_i.walk && report) begin
        strobe_q <= held_q;
      end else begin
        strobe_q <= 1'b0;
      end
      if (ctrl_i.cmd_go) begin
        if (cmd_status == ST_OK) begin
          case (mode_e'(mode_i))
            MODE_CREATE:  occ_q[sidx]  <= runnable_i;
            MODE_SUSPEND: susp_q[sidx] <= 1'b1;
            MODE_RESUME:  susp_q[sidx] <= 1'b0;
            MODE_DELETE:  occ_q[sidx]  <= 1'b0;
            default:      ;
          endcase
        end
      end
      if (ctrl_i.tick_go) begin
        idx_q  <= '0;
        held_q <= 1'b0;
        cnt_q  <= '0;
      end
      if (ctrl_i.walk) begin
        idx_q <= idx_q + 1'b1;
        if (report) begin
          cnt_q  <= cnt_q + 1'b1;
          held_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd_go) begin
      status_q <= cmd_status;
      fired_q  <= 1'b0;
      fslot_q  <= '0;
      last_q   <= 1'b1;
    end else if (ctrl_i.walk && report) begin
      status_q    <= ST_OK;
      fired_q     <= 1'b1;
      fslot_q     <= held_slot_q;
      last_q      <= 1'b0;
      held_slot_q <= idx_ext[SlotFieldW-1:0];
    end else if (ctrl_i.flush) begin
      status_q <= ST_OK;
      fired_q  <= held_q;
      fslot_q  <= held_q ? held_slot_q : '0;
      last_q   <= 1'b1;
    end
  end

  assign done_o       = strobe_q;
  assign status_o     = status_q;
  assign fired_o      = fired_q;
  assign fired_slot_o = fslot_q;
  assign last_o       = last_q;

  `PTRT_ASSERT(a_cnt_bound, cnt_q <= CntW'(MaxResults), "release count above limit")
  `PTRT_ASSERT(a_mid_fires, (strobe_q && !last_q) |-> fired_q, "non-final result without release")
  `PTRT_ASSERT_NEXT(a_flush_out, ctrl_i.flush, strobe_q && last_q, "tick ended without final result")
  `PTRT_ASSERT_NEXT(a_cmd_out, ctrl_i.cmd_go, strobe_q && last_q && !fired_q, "command result missing")

endmodule

FILE: rtl/core/periodic_task_release_table.sv
// Periodic task release table: eight (Slots) task slots.
// Input channel: command style. A transaction is taken on a rising edge with
// start_i high and busy_o low; mode_i selects tick, create, suspend, resume or
// delete, with slot_i, first_delay_i, period_i and runnable_i as operands.
// Result channel: done_o is high for exactly one cycle per result, together
// with status_o, fired_o, fired_slot_o and last_o; last_o marks the final
// result of a transaction. The receiver cannot stall the result channel.
// A command answers in the cycle after it is taken and busy_o stays low, so a
// new transaction may follow in the next cycle.
// A tick walks the slots one per cycle through a single-port-pair timer RAM:
// busy_o is high through the walk and the flush cycle. Releases come out as
// the walk goes on, each one held until the next release or the flush, and
// the final result is on the ports in the cycle after the flush, in the
// first cycle with busy_o low; the next transaction can be taken in that cycle.
// Reset clears all slot flags and the timers read as zero until written; the
// block takes a transaction in the first cycle after reset.
module periodic_task_release_table #(
  parameter int Slots = ptrt_pkg::DefSlots
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [ptrt_pkg::ModeW-1:0]         mode_i,
  input  logic [ptrt_pkg::SlotFieldW-1:0]    slot_i,
  input  logic [ptrt_pkg::TimeW-1:0]         first_delay_i,
  input  logic [ptrt_pkg::TimeW-1:0]         period_i,
  input  logic                               runnable_i,
  output logic                               done_o,
  output logic [ptrt_pkg::StatusW-1:0]       status_o,
  output logic                               fired_o,
  output logic [ptrt_pkg::SlotFieldW-1:0]    fired_slot_o,
  output logic                               last_o
);
  import ptrt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  ptrt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  ptrt_datapath #(
    .Slots (Slots)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .mode_i        (mode_i),
    .slot_i        (slot_i),
    .first_delay_i (first_delay_i),
    .period_i      (period_i),
    .runnable_i    (runnable_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .fired_o       (fired_o),
    .fired_slot_o  (fired_slot_o),
    .last_o        (last_o)
  );

endmodule
